// ===== rtl/swabpls_pkg.sv =====
package swabpls_pkg;

   // Default window size and register reset value
   localparam int unsigned SEG_WINDOW         = 32;
   localparam logic [7:0]  SEG_THRESHOLD_INIT = 8'd16;

   // Field widths
   localparam int unsigned SAMPLE_W = 8;
   localparam int unsigned SLOT_W   = 16;
   localparam int unsigned LEN_W    = 7;
   localparam int unsigned COST_W   = 16;
   localparam int unsigned FRAC_W   = 7;

   // Slope sign codes
   localparam logic [1:0] SLOPE_FLAT = 2'd0;
   localparam logic [1:0] SLOPE_RISE = 2'd1;
   localparam logic [1:0] SLOPE_FALL = 2'd3;

   typedef enum logic [4:0] {
      S_IDLE,
      S_INIT,
      S_COPY_RD,
      S_COPY_WR,
      S_FILL,
      S_SCAN_INIT,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_DECIDE,
      S_SHW_RD,
      S_SHW_WR,
      S_SHC_RD,
      S_SHC_WR,
      S_FIX_RIGHT,
      S_FIX_LEFT,
      S_C_I0,
      S_C_I2,
      S_C_V0,
      S_C_V2,
      S_C_SETUP,
      S_C_DIV,
      S_C_PRD,
      S_C_PACC,
      S_C_DONE,
      S_E_IDX,
      S_E_VAL,
      S_E_OUT,
      S_SH_RD,
      S_SH_WR
   } seg_state_type;

endpackage

// ===== rtl/swab_piecewise_linear_segmenter.sv =====
// Channel   Direction  Ports                                          Transfer
// req       in         req_sample, req_out_slot                       req_valid & req_ready
// rsp       out        rsp_seg_length, rsp_seg_end_value, rsp_seg_slot rsp_valid & rsp_ready
// csr       in         csr_write_data (merge threshold)               csr_write_en
//
// A sample that does not trigger a merge is written in S_IDLE and req_ready stays high.
// A merge loads the work index and cached costs, evaluates each uncached pair cost
// with a serial restoring divide, then rescans the costs and recomputes up to two
// pair costs per merge step, and finally emits the leftmost segment and shifts the
// window out.
// Reset is synchronous; memories are not cleared. A pending result holds only the final emit.
module swab_piecewise_linear_segmenter
   import swabpls_pkg::*;
#(
   parameter int unsigned WINDOW = SEG_WINDOW
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic [SLOT_W-1:0]   req_out_slot,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [LEN_W-1:0]    rsp_seg_length,
   output logic [SAMPLE_W-1:0] rsp_seg_end_value,
   output logic [SLOT_W-1:0]   rsp_seg_slot,
   input  logic                csr_write_en,
   input  logic [7:0]          csr_write_data
);

   localparam int unsigned DEPTH = 2 * WINDOW + 1;
   localparam int unsigned LOW   = WINDOW / 2;
   localparam int unsigned HIGH  = 2 * WINDOW;
   localparam int unsigned PW    = $clog2(2 * WINDOW + 2);
   localparam int unsigned CAW   = $clog2(2 * WINDOW);
   localparam int unsigned CDEP  = 2 * WINDOW;
   localparam int unsigned DVW   = SAMPLE_W + FRAC_W;
   localparam int unsigned DCW   = $clog2(DVW + 1);
   localparam int unsigned IW    = SAMPLE_W + FRAC_W + 3;

   // Memories
   logic [SAMPLE_W-1:0] sw_mem [DEPTH];
   logic [PW-1:0]       wi_mem [DEPTH];
   logic [COST_W-1:0]   cc_mem [CDEP];
   logic [COST_W-1:0]   wc_mem [CDEP];

   logic                sw_we, wi_we, cc_we, wc_we;
   logic [PW-1:0]       sw_waddr, sw_raddr, wi_waddr, wi_raddr;
   logic [CAW-1:0]      cc_waddr, cc_raddr, wc_waddr, wc_raddr;
   logic [SAMPLE_W-1:0] sw_wdata;
   logic [PW-1:0]       wi_wdata;
   logic [COST_W-1:0]   cc_wdata, wc_wdata;
   logic [SAMPLE_W-1:0] sw_rd_ff;
   logic [PW-1:0]       wi_rd_ff;
   logic [COST_W-1:0]   cc_rd_ff, wc_rd_ff;

   // Control state
   seg_state_type state_ff, state_in, ret_ff, ret_in;
   logic [7:0]    thr_ff;
   logic [PW-1:0] fill_ff, fill_in, ccc_ff, ccc_in;
   logic          initial_ff, initial_in;
   logic [1:0]    slope_ff, slope_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   logic [SAMPLE_W-1:0] last_ff, last_in, v0_ff, v0_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [PW-1:0]       fp_ff, fp_in, k_ff, k_in, len_ff, len_in, clen_ff, clen_in;
   logic [PW-1:0]       c_ff, c_in, cj_ff, cj_in, i0_ff, i0_in, i2_ff, i2_in;
   logic [PW-1:0]       di_ff, di_in, rem_ff, rem_in, racc_ff, racc_in;
   logic [PW-1:0]       pk_ff, pk_in, s_ff, s_in;
   logic [COST_W-1:0]   best_ff, best_in, sum_ff, sum_in;
   logic                found_ff, found_in, wcache_ff, wcache_in, neg_ff, neg_in;
   logic [DVW-1:0]      quo_ff, quo_in, qacc_ff, qacc_in;
   logic [DCW-1:0]      dcnt_ff, dcnt_in;
   logic [LEN_W-1:0]    olen_ff, olen_in;
   logic [SAMPLE_W-1:0] oval_ff, oval_in;
   logic [SLOT_W-1:0]   oslot_ff, oslot_in;

   // Scratch for the accept and cost arithmetic
   logic [PW-1:0]        fp;
   logic [1:0]           slope;
   logic                 init_next, trig;
   logic [SAMPLE_W-1:0]  mag;
   logic [PW:0]          rem_sh, r1;
   logic                 ge;
   logic [DVW:0]         q1;
   logic signed [IW-1:0] interp, diff, adiff;
   logic [IW-FRAC_W-1:0] dpt;
   logic [COST_W:0]      sumx;

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_seg_length    = olen_ff;
   assign rsp_seg_end_value = oval_ff;
   assign rsp_seg_slot      = oslot_ff;

   // Next state and datapath
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      fill_in      = fill_ff;
      ccc_in       = ccc_ff;
      initial_in   = initial_ff;
      slope_in     = slope_ff;
      rsp_valid_in = rsp_valid_ff;
      last_in      = last_ff;
      v0_in        = v0_ff;
      slot_in      = slot_ff;
      fp_in        = fp_ff;
      k_in         = k_ff;
      len_in       = len_ff;
      clen_in      = clen_ff;
      c_in         = c_ff;
      cj_in        = cj_ff;
      i0_in        = i0_ff;
      i2_in        = i2_ff;
      di_in        = di_ff;
      rem_in       = rem_ff;
      racc_in      = racc_ff;
      pk_in        = pk_ff;
      s_in         = s_ff;
      best_in      = best_ff;
      sum_in       = sum_ff;
      found_in     = found_ff;
      wcache_in    = wcache_ff;
      neg_in       = neg_ff;
      quo_in       = quo_ff;
      qacc_in      = qacc_ff;
      dcnt_in      = dcnt_ff;
      olen_in      = olen_ff;
      oval_in      = oval_ff;
      oslot_in     = oslot_ff;

      sw_we = 1'b0; sw_waddr = '0; sw_wdata = '0; sw_raddr = '0;
      wi_we = 1'b0; wi_waddr = '0; wi_wdata = '0; wi_raddr = '0;
      cc_we = 1'b0; cc_waddr = '0; cc_wdata = '0; cc_raddr = '0;
      wc_we = 1'b0; wc_waddr = '0; wc_wdata = '0; wc_raddr = '0;

      fp        = (fill_ff >= PW'(DEPTH)) ? PW'(DEPTH - 1) : fill_ff;
      slope     = SLOPE_FLAT;
      if (fill_ff != '0) begin
         if (req_sample > last_ff)
            slope = SLOPE_RISE;
         else if (req_sample < last_ff)
            slope = SLOPE_FALL;
      end
      init_next = initial_ff && !(fp >= PW'(WINDOW));
      trig      = !init_next && (fp >= PW'(LOW)) &&
                  ((slope != slope_ff) || (fp >= PW'(HIGH)));

      mag    = '0;
      rem_sh = {rem_ff, quo_ff[DVW-1]};
      ge     = rem_sh >= {1'b0, di_ff};

      // Incremental interpolation: quotient and remainder of m*|dv|/di
      r1 = {1'b0, racc_ff} + {1'b0, rem_ff};
      q1 = {1'b0, qacc_ff} + {1'b0, quo_ff};
      if (r1 >= {1'b0, di_ff}) begin
         r1 = r1 - {1'b0, di_ff};
         q1 = q1 + 1'b1;
      end
      interp = neg_ff ? IW'({v0_ff, FRAC_W'(0)}) - IW'(q1)
                      : IW'({v0_ff, FRAC_W'(0)}) + IW'(q1);
      diff   = interp - IW'({sw_rd_ff, FRAC_W'(0)});
      adiff  = (diff < 0) ? -diff : diff;
      dpt    = adiff[IW-1:FRAC_W];
      sumx   = {1'b0, sum_ff} + (COST_W+1)'(dpt);

      // Result register drains independently
      if (rsp_valid_ff && rsp_ready)
         rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               sw_we      = 1'b1;
               sw_waddr   = fp;
               sw_wdata   = req_sample;
               last_in    = req_sample;
               initial_in = init_next;
               if (initial_ff && (fp >= PW'(WINDOW)))
                  ccc_in = '0;
               if (trig) begin
                  slope_in = slope;
                  fp_in    = fp;
                  slot_in  = req_out_slot;
                  k_in     = '0;
                  state_in = S_INIT;
               end else begin
                  if (init_next || (fp < PW'(LOW)))
                     slope_in = slope;
                  fill_in = fp + 1'b1;
               end
            end
         end

         // Work index starts as the identity
         S_INIT: begin
            wi_we    = 1'b1;
            wi_waddr = k_ff;
            wi_wdata = k_ff;
            if (k_ff == fp_ff - 1'b1) begin
               k_in     = '0;
               state_in = (ccc_ff != '0) ? S_COPY_RD : S_FILL;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end

         // Reuse cached costs
         S_COPY_RD: begin
            cc_raddr = k_ff[CAW-1:0];
            state_in = S_COPY_WR;
         end
         S_COPY_WR: begin
            wc_we    = 1'b1;
            wc_waddr = k_ff[CAW-1:0];
            wc_wdata = cc_rd_ff;
            k_in     = k_ff + 1'b1;
            state_in = (k_ff + 1'b1 == ccc_ff) ? S_FILL : S_COPY_RD;
         end

         // Compute the costs not yet cached
         S_FILL: begin
            if (k_ff + 2'd2 < fp_ff) begin
               cj_in     = k_ff;
               wcache_in = 1'b1;
               ret_in    = S_FILL;
               k_in      = k_ff + 1'b1;
               state_in  = S_C_I0;
            end else begin
               ccc_in   = fp_ff - 2'd2;
               len_in   = fp_ff;
               clen_in  = fp_ff - 2'd2;
               state_in = S_SCAN_INIT;
            end
         end

         // Find the cheapest pair, lowest position on ties
         S_SCAN_INIT: begin
            k_in     = '0;
            best_in  = '1;
            found_in = 1'b0;
            state_in = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            wc_raddr = k_ff[CAW-1:0];
            state_in = (k_ff >= clen_ff) ? S_DECIDE : S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (wc_rd_ff < best_ff) begin
               best_in  = wc_rd_ff;
               c_in     = k_ff;
               found_in = 1'b1;
            end
            k_in     = k_ff + 1'b1;
            state_in = S_SCAN_RD;
         end
         S_DECIDE: begin
            if (!found_ff || (best_ff >= COST_W'(thr_ff))) begin
               state_in = S_E_IDX;
            end else begin
               k_in     = c_ff + 1'b1;
               state_in = S_SHW_RD;
            end
         end

         // Drop point c+1 from the work index
         S_SHW_RD: begin
            wi_raddr = k_ff + 1'b1;
            if (k_ff + 1'b1 < len_ff) begin
               state_in = S_SHW_WR;
            end else begin
               k_in     = c_ff + 1'b1;
               state_in = S_SHC_RD;
            end
         end
         S_SHW_WR: begin
            wi_we    = 1'b1;
            wi_waddr = k_ff;
            wi_wdata = wi_rd_ff;
            k_in     = k_ff + 1'b1;
            state_in = S_SHW_RD;
         end

         // Close the gap in the work costs
         S_SHC_RD: begin
            wc_raddr = k_ff[CAW-1:0];
            if (k_ff < clen_ff) begin
               state_in = S_SHC_WR;
            end else begin
               len_in   = len_ff - 1'b1;
               clen_in  = clen_ff - 1'b1;
               state_in = S_FIX_RIGHT;
            end
         end
         S_SHC_WR: begin
            wc_we    = 1'b1;
            wc_waddr = CAW'(k_ff - 1'b1);
            wc_wdata = wc_rd_ff;
            k_in     = k_ff + 1'b1;
            state_in = S_SHC_RD;
         end

         // Recompute the neighbors of the removed point
         S_FIX_RIGHT: begin
            if (c_ff < clen_ff) begin
               cj_in     = c_ff;
               wcache_in = 1'b0;
               ret_in    = S_FIX_LEFT;
               state_in  = S_C_I0;
            end else begin
               state_in = S_FIX_LEFT;
            end
         end
         S_FIX_LEFT: begin
            if (c_ff != '0) begin
               cj_in     = c_ff - 1'b1;
               wcache_in = 1'b0;
               ret_in    = S_SCAN_INIT;
               state_in  = S_C_I0;
            end else begin
               state_in = S_SCAN_INIT;
            end
         end

         // Cost unit: fetch end points
         S_C_I0: begin
            wi_raddr = cj_ff;
            state_in = S_C_I2;
         end
         S_C_I2: begin
            i0_in    = wi_rd_ff;
            wi_raddr = cj_ff + 2'd2;
            state_in = S_C_V0;
         end
         S_C_V0: begin
            i2_in    = wi_rd_ff;
            sw_raddr = i0_ff;
            state_in = S_C_V2;
         end
         S_C_V2: begin
            v0_in    = sw_rd_ff;
            sw_raddr = i2_ff;
            state_in = S_C_SETUP;
         end
         S_C_SETUP: begin
            if (sw_rd_ff >= v0_ff) begin
               neg_in = 1'b0;
               mag    = sw_rd_ff - v0_ff;
            end else begin
               neg_in = 1'b1;
               mag    = v0_ff - sw_rd_ff;
            end
            quo_in   = {mag, FRAC_W'(0)};
            rem_in   = '0;
            di_in    = i2_ff - i0_ff;
            dcnt_in  = '0;
            state_in = S_C_DIV;
         end

         // Restoring divide, one quotient bit per cycle
         S_C_DIV: begin
            rem_in  = ge ? PW'(rem_sh - {1'b0, di_ff}) : PW'(rem_sh);
            quo_in  = {quo_ff[DVW-2:0], ge};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCW'(DVW - 1)) begin
               qacc_in  = '0;
               racc_in  = '0;
               sum_in   = '0;
               pk_in    = i0_ff + 1'b1;
               state_in = S_C_PRD;
            end
         end

         // Accumulate deviation over interior points
         S_C_PRD: begin
            sw_raddr = pk_ff;
            state_in = (pk_ff < i2_ff) ? S_C_PACC : S_C_DONE;
         end
         S_C_PACC: begin
            qacc_in  = DVW'(q1);
            racc_in  = PW'(r1);
            sum_in   = sumx[COST_W] ? '1 : sumx[COST_W-1:0];
            pk_in    = pk_ff + 1'b1;
            state_in = S_C_PRD;
         end
         S_C_DONE: begin
            wc_we    = 1'b1;
            wc_waddr = cj_ff[CAW-1:0];
            wc_wdata = sum_ff;
            if (wcache_ff) begin
               cc_we    = 1'b1;
               cc_waddr = cj_ff[CAW-1:0];
               cc_wdata = sum_ff;
            end
            state_in = ret_ff;
         end

         // Emit the leftmost segment
         S_E_IDX: begin
            wi_raddr = PW'(1);
            state_in = S_E_VAL;
         end
         S_E_VAL: begin
            s_in     = wi_rd_ff;
            sw_raddr = wi_rd_ff;
            state_in = S_E_OUT;
         end
         S_E_OUT: begin
            sw_raddr = s_ff;
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               olen_in      = LEN_W'(s_ff);
               oval_in      = sw_rd_ff;
               oslot_in     = slot_ff;
               k_in         = s_ff;
               state_in     = S_SH_RD;
            end
         end

         // Shift window and cached costs left by the segment length
         S_SH_RD: begin
            sw_raddr = k_ff;
            cc_raddr = k_ff[CAW-1:0];
            if (k_ff <= fp_ff) begin
               state_in = S_SH_WR;
            end else begin
               fill_in  = fp_ff - s_ff + 1'b1;
               ccc_in   = (ccc_ff > s_ff) ? ccc_ff - s_ff : '0;
               state_in = S_IDLE;
            end
         end
         S_SH_WR: begin
            sw_we    = 1'b1;
            sw_waddr = k_ff - s_ff;
            sw_wdata = sw_rd_ff;
            if (k_ff < ccc_ff) begin
               cc_we    = 1'b1;
               cc_waddr = CAW'(k_ff - s_ff);
               cc_wdata = cc_rd_ff;
            end
            k_in     = k_ff + 1'b1;
            state_in = S_SH_RD;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Memory ports
   always_ff @(posedge clock) begin
      if (sw_we)
         sw_mem[sw_waddr] <= sw_wdata;
      sw_rd_ff <= sw_mem[sw_raddr];
   end

   always_ff @(posedge clock) begin
      if (wi_we)
         wi_mem[wi_waddr] <= wi_wdata;
      wi_rd_ff <= wi_mem[wi_raddr];
   end

   always_ff @(posedge clock) begin
      if (cc_we)
         cc_mem[cc_waddr] <= cc_wdata;
      cc_rd_ff <= cc_mem[cc_raddr];
   end

   always_ff @(posedge clock) begin
      if (wc_we)
         wc_mem[wc_waddr] <= wc_wdata;
      wc_rd_ff <= wc_mem[wc_raddr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         thr_ff       <= SEG_THRESHOLD_INIT;
         fill_ff      <= '0;
         ccc_ff       <= '0;
         initial_ff   <= 1'b1;
         slope_ff     <= SLOPE_FLAT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         if (csr_write_en)
            thr_ff <= csr_write_data;
         fill_ff      <= fill_in;
         ccc_ff       <= ccc_in;
         initial_ff   <= initial_in;
         slope_ff     <= slope_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      last_ff   <= last_in;
      v0_ff     <= v0_in;
      slot_ff   <= slot_in;
      fp_ff     <= fp_in;
      k_ff      <= k_in;
      len_ff    <= len_in;
      clen_ff   <= clen_in;
      c_ff      <= c_in;
      cj_ff     <= cj_in;
      i0_ff     <= i0_in;
      i2_ff     <= i2_in;
      di_ff     <= di_in;
      rem_ff    <= rem_in;
      racc_ff   <= racc_in;
      pk_ff     <= pk_in;
      s_ff      <= s_in;
      best_ff   <= best_in;
      sum_ff    <= sum_in;
      found_ff  <= found_in;
      wcache_ff <= wcache_in;
      neg_ff    <= neg_in;
      quo_ff    <= quo_in;
      qacc_ff   <= qacc_in;
      dcnt_ff   <= dcnt_in;
      olen_ff   <= olen_in;
      oval_ff   <= oval_in;
      oslot_ff  <= oslot_in;
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import swabpls_pkg::*;

   localparam int unsigned WIN   = SEG_WINDOW;
   localparam int unsigned LOWB  = WIN / 2;
   localparam int unsigned HIGHB = WIN * 2;
   localparam int unsigned DEPTH = HIGHB + 1;
   localparam int unsigned TAIL_CYCLES = 400000;
   localparam longint     CYCLE_LIMIT = 64'd60000000;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [SLOT_W-1:0]   slot;
   } sample_item_t;

   typedef struct packed {
      logic [LEN_W-1:0]    seg_len;
      logic [SAMPLE_W-1:0] end_val;
      logic [SLOT_W-1:0]   slot;
   } segment_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic [SLOT_W-1:0]   req_out_slot = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [LEN_W-1:0]    rsp_seg_length;
   logic [SAMPLE_W-1:0] rsp_seg_end_value;
   logic [SLOT_W-1:0]   rsp_seg_slot;
   logic                csr_write_en = 1'b0;
   logic [7:0]          csr_write_data = '0;

   swab_piecewise_linear_segmenter #(.WINDOW(WIN)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_sample(req_sample), .req_out_slot(req_out_slot),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_seg_length(rsp_seg_length), .rsp_seg_end_value(rsp_seg_end_value),
      .rsp_seg_slot(rsp_seg_slot),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data)
   );

   always #4 clock = ~clock;

   // Segmenter mirror state
   logic [7:0]  thresh;
   logic [7:0]  win_samp [DEPTH];
   logic [15:0] win_cost [DEPTH];
   logic [6:0]  wk_idx [DEPTH];
   logic [7:0]  wk_val [DEPTH];
   logic [15:0] wk_cost [DEPTH];
   int unsigned fill_pos, win_size, cost_count;
   bit          filling;
   logic [1:0]  cur_slope;

   sample_item_t pending_items[$];
   segment_t     expected_segs[$];
   int           mismatches = 0;
   int           seg_seen = 0;
   int           items_sent = 0;
   longint       cycles = 0;
   int           send_idle_pct = 11;
   int           recv_idle_pct = 75;
   bit           send_hold = 1'b0;
   int           recv_hold_cycles = 0;
   int           hold_count = 0;
   bit           accepted_last = 1'b0;

   function automatic logic [1:0] slope_of(int unsigned p);
      if (p == 0 || p >= DEPTH) return SLOPE_FLAT;
      if (win_samp[p] > win_samp[p-1]) return SLOPE_RISE;
      if (win_samp[p] < win_samp[p-1]) return SLOPE_FALL;
      return SLOPE_FLAT;
   endfunction

   // Interpolation error of dropping point j+1
   function automatic logic [15:0] pair_cost(int unsigned j);
      int i0, i2, v0, dv, di, interp, d;
      int unsigned sum;
      sum = 0;
      if (j + 2 >= DEPTH) return 16'd0;
      i0 = wk_idx[j];
      i2 = wk_idx[j+2];
      v0 = wk_val[j];
      dv = (int'(wk_val[j+2]) - v0) * 128;
      di = i2 - i0;
      if (di <= 0) return 16'd0;
      for (int k = i0 + 1; k < i2 && k < DEPTH; k++) begin
         interp = v0 * 128 + ((k - i0) * dv) / di;
         d = interp - int'(win_samp[k]) * 128;
         if (d < 0) d = -d;
         sum += d >> 7;
         if (sum > 65535) sum = 65535;
      end
      return sum[15:0];
   endfunction

   function automatic void segmenter_reset();
      thresh = SEG_THRESHOLD_INIT;
      fill_pos = 0;
      win_size = WIN;
      cost_count = 0;
      filling = 1'b1;
      cur_slope = SLOPE_FLAT;
   endfunction

   // Advance the mirror by one sample, queue any emitted segment
   function automatic void segment_predict(sample_item_t it);
      int unsigned fp, n, len, clen, s, c;
      bit          merge;
      bit          found;
      logic [15:0] best;
      segment_t    seg;
      fp = fill_pos;
      merge = 1'b0;
      if (fp >= DEPTH) fp = DEPTH - 1;
      win_samp[fp] = it.sample;
      if (filling && fp >= win_size) begin
         filling = 1'b0;
         cost_count = 0;
      end
      if (!filling && fp >= LOWB) begin
         if (slope_of(fp) != cur_slope || fp >= HIGHB) begin
            merge = 1'b1;
            win_size = (fp >= HIGHB) ? HIGHB : fp;
         end
      end else begin
         cur_slope = slope_of(fp);
      end
      if (merge) begin
         n = win_size;
         for (int unsigned k = 0; k < n; k++) begin
            wk_idx[k] = k[6:0];
            wk_val[k] = win_samp[k];
            if (k < cost_count) wk_cost[k] = win_cost[k];
         end
         for (int unsigned k = cost_count; k + 2 < n; k++) begin
            win_cost[k] = pair_cost(k);
            wk_cost[k] = win_cost[k];
         end
         cost_count = n - 2;
         len = n;
         clen = n - 2;
         forever begin
            best = 16'hFFFF;
            c = 0;
            found = 1'b0;
            for (int unsigned i = 0; i < clen; i++) begin
               if (wk_cost[i] < best) begin
                  best = wk_cost[i];
                  c = i;
                  found = 1'b1;
               end
            end
            if (!found || best >= {8'd0, thresh}) break;
            for (int unsigned i = c + 1; i + 1 < len; i++) begin
               wk_idx[i] = wk_idx[i+1];
               wk_val[i] = wk_val[i+1];
            end
            for (int unsigned i = c + 1; i < clen; i++) wk_cost[i-1] = wk_cost[i];
            len--;
            clen--;
            if (c < clen) wk_cost[c] = pair_cost(c);
            if (c > 0) wk_cost[c-1] = pair_cost(c - 1);
         end
         s = wk_idx[1];
         seg.seg_len = s[6:0];
         seg.end_val = wk_val[1];
         seg.slot = it.slot;
         expected_segs.push_back(seg);
         cur_slope = slope_of(fp);
         for (int unsigned k = s; k <= fp; k++) begin
            win_samp[k-s] = win_samp[k];
            if (k < cost_count) win_cost[k-s] = win_cost[k];
         end
         fp -= s;
         win_size -= s;
         cost_count = (cost_count > s) ? cost_count - s : 0;
      end
      fill_pos = fp + 1;
   endfunction

   // Driver: offers queued samples at the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || accepted_last) begin
            if (pending_items.size() > 0 && !send_hold &&
                $urandom_range(99, 0) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_sample <= pending_items[0].sample;
               req_out_slot <= pending_items[0].slot;
               pending_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: ready pattern and the long hold-off, counted here
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_count < recv_hold_cycles) begin
            rsp_ready <= 1'b0;
            hold_count <= hold_count + 1;
         end else begin
            rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
         end
      end
   end

   // Monitor: samples transfers at the rising edge
   always @(posedge clock) begin
      segment_t want;
      cycles <= cycles + 1;
      accepted_last <= 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            accepted_last <= 1'b1;
            items_sent <= items_sent + 1;
            segment_predict('{sample: req_sample, slot: req_out_slot});
         end
         if (rsp_valid && rsp_ready) begin
            seg_seen <= seg_seen + 1;
            if (expected_segs.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected segment len=%0d val=%0d slot=%0d",
                           rsp_seg_length, rsp_seg_end_value, rsp_seg_slot);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_segs.pop_front();
               if (want.seg_len !== rsp_seg_length || want.end_val !== rsp_seg_end_value ||
                   want.slot !== rsp_seg_slot) begin
                  if (mismatches < 10)
                     $display("segment mismatch: exp len=%0d val=%0d slot=%0d, got %0d %0d %0d",
                              want.seg_len, want.end_val, want.slot, rsp_seg_length,
                              rsp_seg_end_value, rsp_seg_slot);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end

   // Timeout watchdog
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("testbench: done, errors");
         $finish;
      end
   end

   task automatic wait_cycles(int n);
      repeat (n) @(posedge clock);
   endtask

   // Wait until the block has taken every queued sample and emitted all segments
   task automatic drain();
      while (pending_items.size() > 0 || req_valid) @(posedge clock);
      while (expected_segs.size() > 0) @(posedge clock);
      wait_cycles(TAIL_CYCLES);
   endtask

   task automatic write_threshold(logic [7:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      thresh = value;
   endtask

   task automatic push_sample(int unsigned v, int unsigned slot);
      sample_item_t it;
      it.sample = v[7:0];
      it.slot = slot[15:0];
      pending_items.push_back(it);
   endtask

   // Random sensor-like trace: ramps with noise, flats, and jumps
   task automatic push_random(int count);
      int v, dir, run;
      v = $urandom_range(255, 0);
      dir = 0;
      run = 0;
      for (int i = 0; i < count; i++) begin
         if (run == 0) begin
            run = $urandom_range(40, 2);
            dir = $urandom_range(2, 0) - 1;
         end
         run--;
         case ($urandom_range(9, 0))
            0: v = $urandom_range(255, 0);
            1, 2: v = v;
            default: v = v + dir * $urandom_range(12, 0) + $urandom_range(2, 0) - 1;
         endcase
         if (v < 0) v = 0;
         if (v > 255) v = 255;
         push_sample(v, $urandom_range(65535, 0));
      end
   endtask

   initial begin
      segmenter_reset();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes, slope reversals, a flat pair, slot extremes
      push_sample(0, 0);
      push_sample(255, 16'hFFFF);
      for (int i = 0; i < 10; i++) push_sample(i * 25, i);
      for (int i = 0; i < 10; i++) push_sample(255 - i * 25, 16'hAAAA ^ i);
      push_sample(128, 16'h5555);
      push_sample(128, 16'h8000);
      push_sample(1, 16'h0001);
      push_random(20);
      drain();

      // Threshold zero: nothing ever merges; long receiver stall fills the block
      write_threshold(8'd0);
      send_idle_pct = 75;
      recv_idle_pct = 11;
      recv_hold_cycles = 300000;
      push_random(20);
      drain();

      // Threshold max: merging as far as possible
      write_threshold(8'd255);
      push_random(20);
      drain();

      // No idling at all; the sender pauses until every result has come
      write_threshold(8'($urandom_range(64, 1)));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      push_random(15);
      while (pending_items.size() > 8) @(posedge clock);
      send_hold = 1'b1;
      while (req_valid) @(posedge clock);
      while (expected_segs.size() > 0) @(posedge clock);
      send_hold = 1'b0;
      drain();

      $display("run covered %0d samples and %0d segments at thresholds 16, 0, 255 and random",
               items_sent, seg_seen);
      if (mismatches == 0 && expected_segs.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("mismatches: %0d", mismatches);
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
